// File: src/efra_pkg.sv
// Package with the types, constants and state codes of the earliest free room allocator.
package efra_pkg;

    // Built maximum number of resources and fixed field widths.
    localparam int MAX_RESOURCES_DEF = 16;
    localparam int TIME_W            = 48;
    localparam int IN_TIME_W         = 32;
    localparam int COUNT_W           = 32;
    localparam int CFG_W             = 5;
    localparam int OUT_IDX_W         = 4;

    // Reset value of the resources_in_use register.
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // One job request.
    typedef struct packed {
        logic [IN_TIME_W-1:0] start_time;
        logic [IN_TIME_W-1:0] end_time;
        logic                 last_job;
    } job_t;

    // One grant result.
    typedef struct packed {
        logic [OUT_IDX_W-1:0] assigned_resource;
        logic [TIME_W-1:0]    actual_start;
        logic [TIME_W-1:0]    actual_end;
        logic                 delayed;
        logic [OUT_IDX_W-1:0] most_used_resource;
        logic                 set_done;
    } grant_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

endpackage

// File: src/earliest_free_room_allocator_unit.sv
// Earliest free room allocator: scans resource end times with one comparator per job.
// The scan reads one table entry a cycle and stops at the first free resource or at the
// last active one; the job then passes the update and finish states before its grant is
// registered. A new job is taken only once the previous one has left the finish state.
// A finished grant waits in the output register while the next job is taken.
// Reset (rst_n low, asynchronous) clears all tables through valid bits and sets the
// resource count to 16; tables also clear when a job marked last leaves with its grant.
module earliest_free_room_allocator_unit #(
    parameter int MAX_RESOURCES = efra_pkg::MAX_RESOURCES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [efra_pkg::CFG_W-1:0]    cfg_write_data,
    input  logic                          job_valid,
    output logic                          job_stall,
    input  efra_pkg::job_t                job,
    output logic                          grant_valid,
    input  logic                          grant_stall,
    output efra_pkg::grant_t              grant
);

    localparam int IDX_W     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int RES_CNT_W = $clog2(MAX_RESOURCES + 1);
    localparam int ACT_W     = (RES_CNT_W > efra_pkg::CFG_W) ? RES_CNT_W : efra_pkg::CFG_W;
    localparam int TW        = efra_pkg::TIME_W;
    localparam int ITW       = efra_pkg::IN_TIME_W;
    localparam int CW        = efra_pkg::COUNT_W;

    // Table storage: end times and use counts, validity kept in flip-flops.
    logic [TW-1:0] busy_mem [MAX_RESOURCES];
    logic [CW-1:0] cnt_mem  [MAX_RESOURCES];

    efra_pkg::state_t          state_reg, state_next;
    logic [efra_pkg::CFG_W-1:0] cfg_reg;
    logic [ITW-1:0]            start_reg, start_next;
    logic [ITW-1:0]            dur_reg, dur_next;
    logic                      last_reg, last_next;
    logic [IDX_W-1:0]          last_idx_reg, last_idx_next;
    logic [IDX_W-1:0]          chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]          earliest_idx_reg, earliest_idx_next;
    logic [TW-1:0]             earliest_val_reg, earliest_val_next;
    logic                      late_reg, late_next;
    logic [IDX_W-1:0]          pick_reg, pick_next;
    logic [TW-1:0]             act_start_reg, act_start_next;
    logic [TW-1:0]             act_end_reg, act_end_next;
    logic [CW-1:0]             new_cnt_reg, new_cnt_next;
    logic [CW-1:0]             best_cnt_reg, best_cnt_next;
    logic [IDX_W-1:0]          best_idx_reg, best_idx_next;
    logic [MAX_RESOURCES-1:0]  valid_reg, valid_next;
    logic [TW-1:0]             busy_rd_reg;
    logic [CW-1:0]             cnt_rd_reg;
    logic                      vld_rd_reg;
    efra_pkg::grant_t          out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      job_take;
    logic                      out_free;
    logic [IDX_W-1:0]          rd_addr;
    logic                      tbl_we;
    logic [ACT_W-1:0]          active;
    logic [TW-1:0]             entry_busy;
    logic                      free_hit;
    logic                      earlier;
    logic                      scan_end;
    logic [IDX_W-1:0]          scan_pick;
    logic [TW-1:0]             upd_start;
    logic [TW:0]               upd_sum;
    logic [CW-1:0]             cur_cnt;
    logic                      better;
    logic [IDX_W-1:0]          best_idx_upd;

    assign job_stall   = (state_reg != efra_pkg::ST_IDLE);
    assign job_take    = job_valid && !job_stall;
    assign out_free    = !out_valid_reg || !grant_stall;
    assign grant_valid = out_valid_reg;
    assign grant       = out_reg;

    // Number of active resources, with zero taken as one and large values clamped.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            active = ACT_W'(1);
        end
        else if (ACT_W'(cfg_reg) > ACT_W'(MAX_RESOURCES))
        begin
            active = ACT_W'(MAX_RESOURCES);
        end
        else
        begin
            active = ACT_W'(cfg_reg);
        end
    end

    // Scan compare on the entry that the table read returned this cycle.
    always_comb
    begin
        entry_busy = vld_rd_reg ? busy_rd_reg : '0;
        free_hit   = (entry_busy <= TW'(start_reg));
        earlier    = (chk_idx_reg == '0) || (entry_busy < earliest_val_reg);
        scan_end   = free_hit || (chk_idx_reg == last_idx_reg);
        scan_pick  = free_hit ? chk_idx_reg : (earlier ? chk_idx_reg : earliest_idx_reg);
    end

    // Update arithmetic: delayed start, saturating end time and use count.
    always_comb
    begin
        upd_start = late_reg ? earliest_val_reg : TW'(start_reg);
        upd_sum   = {1'b0, upd_start} + (TW + 1)'(dur_reg);
        cur_cnt   = vld_rd_reg ? cnt_rd_reg : '0;
    end

    // Most-used tracking with the new count of the picked resource.
    always_comb
    begin
        better = (new_cnt_reg > best_cnt_reg) ||
                 ((new_cnt_reg == best_cnt_reg) && (pick_reg < best_idx_reg));
        best_idx_upd = better ? pick_reg : best_idx_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            efra_pkg::ST_IDLE:
            begin
                if (job_take)
                begin
                    state_next = efra_pkg::ST_SCAN;
                end
            end
            efra_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = efra_pkg::ST_UPDATE;
                end
            end
            efra_pkg::ST_UPDATE:
            begin
                state_next = efra_pkg::ST_FINISH;
            end
            efra_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = efra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = efra_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output values for each state.
    always_comb
    begin
        start_next        = start_reg;
        dur_next          = dur_reg;
        last_next         = last_reg;
        last_idx_next     = last_idx_reg;
        chk_idx_next      = chk_idx_reg;
        earliest_idx_next = earliest_idx_reg;
        earliest_val_next = earliest_val_reg;
        late_next         = late_reg;
        pick_next         = pick_reg;
        act_start_next    = act_start_reg;
        act_end_next      = act_end_reg;
        new_cnt_next      = new_cnt_reg;
        best_cnt_next     = best_cnt_reg;
        best_idx_next     = best_idx_reg;
        valid_next        = valid_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && grant_stall;
        rd_addr           = pick_reg;
        tbl_we            = 1'b0;
        case (state_reg)
            efra_pkg::ST_IDLE:
            begin
                rd_addr = '0;
                if (job_take)
                begin
                    start_next    = job.start_time;
                    dur_next      = (job.end_time > job.start_time) ?
                                    (job.end_time - job.start_time) : '0;
                    last_next     = job.last_job;
                    last_idx_next = IDX_W'(active - ACT_W'(1));
                    chk_idx_next  = '0;
                end
            end
            efra_pkg::ST_SCAN:
            begin
                if (earlier)
                begin
                    earliest_idx_next = chk_idx_reg;
                    earliest_val_next = entry_busy;
                end
                chk_idx_next = chk_idx_reg + IDX_W'(1);
                rd_addr      = chk_idx_reg + IDX_W'(1);
                if (scan_end)
                begin
                    pick_next = scan_pick;
                    late_next = !free_hit;
                    rd_addr   = scan_pick;
                end
            end
            efra_pkg::ST_UPDATE:
            begin
                tbl_we         = 1'b1;
                act_start_next = upd_start;
                act_end_next   = upd_sum[TW] ? '1 : upd_sum[TW-1:0];
                new_cnt_next   = (&cur_cnt) ? cur_cnt : cur_cnt + CW'(1);
                valid_next[pick_reg] = 1'b1;
            end
            efra_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_next.assigned_resource  = efra_pkg::OUT_IDX_W'(pick_reg);
                    out_next.actual_start       = act_start_reg;
                    out_next.actual_end         = act_end_reg;
                    out_next.delayed            = late_reg;
                    out_next.most_used_resource = efra_pkg::OUT_IDX_W'(best_idx_upd);
                    out_next.set_done           = last_reg;
                    out_valid_next              = 1'b1;
                    if (last_reg)
                    begin
                        best_cnt_next = '0;
                        best_idx_next = '0;
                        valid_next    = '0;
                    end
                    else if (better)
                    begin
                        best_cnt_next = new_cnt_reg;
                        best_idx_next = pick_reg;
                    end
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= efra_pkg::ST_IDLE;
            cfg_reg       <= efra_pkg::CFG_RESET;
            best_cnt_reg  <= '0;
            best_idx_reg  <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            best_cnt_reg  <= best_cnt_next;
            best_idx_reg  <= best_idx_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                cfg_reg <= cfg_write_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        start_reg        <= start_next;
        dur_reg          <= dur_next;
        last_reg         <= last_next;
        last_idx_reg     <= last_idx_next;
        chk_idx_reg      <= chk_idx_next;
        earliest_idx_reg <= earliest_idx_next;
        earliest_val_reg <= earliest_val_next;
        late_reg         <= late_next;
        pick_reg         <= pick_next;
        act_start_reg    <= act_start_next;
        act_end_reg      <= act_end_next;
        new_cnt_reg      <= new_cnt_next;
        out_reg          <= out_next;
    end

    // Table memories with a registered read port and one write port.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            busy_mem[pick_reg] <= act_end_next;
            cnt_mem[pick_reg]  <= new_cnt_next;
        end
        busy_rd_reg <= busy_mem[rd_addr];
        cnt_rd_reg  <= cnt_mem[rd_addr];
    end

    // Validity of the entry read alongside the table data.
    always_ff @(posedge clk)
    begin
        vld_rd_reg <= valid_reg[rd_addr];
    end

    // A finishing job with a free output register always shows a grant next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == efra_pkg::ST_FINISH && out_free) |=> grant_valid)
        else $error("finished job produced no grant");

    // The scan never runs past the last active resource.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == efra_pkg::ST_SCAN) |-> (chk_idx_reg <= last_idx_reg))
        else $error("scan index beyond active resources");

    // A grant never ends before it starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        grant_valid |-> (grant.actual_end >= grant.actual_start))
        else $error("grant end precedes start");

    // A job that was not delayed starts at its requested 32-bit time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (grant_valid && !grant.delayed) |-> (grant.actual_start[TW-1:ITW] == '0))
        else $error("undelayed grant start out of range");

endmodule

// File: test/tb.sv
// Testbench for the earliest free room allocator: directed table, random jobs, room predictor.
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 8;
    localparam int JOBS_PER_PHASE = 50;
    localparam logic [efra_pkg::TIME_W-1:0] TIME_MAX = '1;
    localparam logic [efra_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    // One line of the directed table; the grant is typed in only where typed is set.
    typedef struct {
        bit                           wr;
        logic [efra_pkg::CFG_W-1:0]   cfg;
        efra_pkg::job_t               j;
        bit                           typed;
        efra_pkg::grant_t             g;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [efra_pkg::CFG_W-1:0] cfg_write_data = '0;
    logic job_valid = 1'b0;
    logic job_stall;
    efra_pkg::job_t job = '0;
    logic grant_valid;
    logic grant_stall = 1'b0;
    efra_pkg::grant_t grant;

    // Predictor copy of the block state and its register.
    logic [efra_pkg::TIME_W-1:0]    room_busy_until [efra_pkg::MAX_RESOURCES_DEF];
    logic [efra_pkg::COUNT_W-1:0]   room_use_count [efra_pkg::MAX_RESOURCES_DEF];
    logic [efra_pkg::COUNT_W-1:0]   top_count;
    logic [efra_pkg::OUT_IDX_W-1:0] top_room;
    logic [efra_pkg::CFG_W-1:0]     room_limit;

    efra_pkg::grant_t pending_grants [$];
    plan_row_t directed_plan [$];
    int mismatches = 0;
    int cycle_count = 0;
    int unsigned send_gap_pct = 0;
    int unsigned grant_stall_pct = 0;
    int burst_req = 0;
    int burst_seen = 0;
    int hold_left = 0;

    earliest_free_room_allocator_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .job_valid      (job_valid),
        .job_stall      (job_stall),
        .job            (job),
        .grant_valid    (grant_valid),
        .grant_stall    (grant_stall),
        .grant          (grant)
    );

    always #4 clk = ~clk;

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Number of rooms the register actually enables.
    function automatic int active_rooms();
        if (room_limit == 0)
            return 1;
        if (room_limit > efra_pkg::MAX_RESOURCES_DEF)
            return efra_pkg::MAX_RESOURCES_DEF;
        return int'(room_limit);
    endfunction

    // Assign one job to a room and advance the predicted tables.
    function automatic efra_pkg::grant_t allocate_room(input efra_pkg::job_t j);
        logic [efra_pkg::TIME_W-1:0] start48;
        logic [efra_pkg::TIME_W-1:0] span;
        logic [efra_pkg::TIME_W-1:0] begin_at;
        logic [efra_pkg::TIME_W-1:0] finish_at;
        logic [efra_pkg::OUT_IDX_W-1:0] pick;
        logic [efra_pkg::OUT_IDX_W-1:0] earliest;
        bit found;
        efra_pkg::grant_t g;
        start48 = efra_pkg::TIME_W'(j.start_time);
        span = '0;
        if (j.end_time > j.start_time)
            span = efra_pkg::TIME_W'(j.end_time - j.start_time);
        pick = '0;
        earliest = '0;
        found = 1'b0;
        // Lowest free room wins; otherwise remember the room that frees first.
        for (int k = 0; k < active_rooms(); k++)
        begin
            if (!found)
            begin
                if (room_busy_until[k] <= start48)
                begin
                    pick = k[efra_pkg::OUT_IDX_W-1:0];
                    found = 1'b1;
                end
                else if (room_busy_until[k] < room_busy_until[earliest])
                    earliest = k[efra_pkg::OUT_IDX_W-1:0];
            end
        end
        if (!found)
            pick = earliest;
        begin_at = found ? start48 : room_busy_until[pick];
        if (span > TIME_MAX - begin_at)
            finish_at = TIME_MAX;
        else
            finish_at = begin_at + span;
        room_busy_until[pick] = finish_at;
        // Use counts saturate; the leader only changes on a strictly better count, or an equal count at a lower index.
        if (room_use_count[pick] != COUNT_MAX)
            room_use_count[pick]++;
        if (room_use_count[pick] > top_count ||
            (room_use_count[pick] == top_count && pick < top_room))
        begin
            top_count = room_use_count[pick];
            top_room = pick;
        end
        g.assigned_resource = pick;
        g.actual_start = begin_at;
        g.actual_end = finish_at;
        g.delayed = !found;
        g.most_used_resource = top_room;
        g.set_done = j.last_job;
        // The end of a set clears every table.
        if (j.last_job)
        begin
            for (int k = 0; k < efra_pkg::MAX_RESOURCES_DEF; k++)
            begin
                room_busy_until[k] = '0;
                room_use_count[k] = '0;
            end
            top_count = '0;
            top_room = '0;
        end
        return g;
    endfunction

    task automatic plan_row(input bit wr, input logic [efra_pkg::CFG_W-1:0] cfg,
                            input logic [efra_pkg::IN_TIME_W-1:0] s,
                            input logic [efra_pkg::IN_TIME_W-1:0] e,
                            input bit last, input bit typed = 1'b0,
                            input logic [efra_pkg::OUT_IDX_W-1:0] room = '0,
                            input logic [efra_pkg::TIME_W-1:0] a_start = '0,
                            input logic [efra_pkg::TIME_W-1:0] a_end = '0,
                            input bit dly = 1'b0,
                            input logic [efra_pkg::OUT_IDX_W-1:0] top = '0);
        plan_row_t row;
        row.wr = wr;
        row.cfg = cfg;
        row.j.start_time = s;
        row.j.end_time = e;
        row.j.last_job = last;
        row.typed = typed;
        row.g.assigned_resource = room;
        row.g.actual_start = a_start;
        row.g.actual_end = a_end;
        row.g.delayed = dly;
        row.g.most_used_resource = top;
        row.g.set_done = last;
        directed_plan.push_back(row);
    endtask

    // Offer one job, wait for its transfer and record the grant it must produce.
    task automatic send_job(input efra_pkg::job_t j, input bit typed,
                            input efra_pkg::grant_t typed_g);
        efra_pkg::grant_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            job_valid <= 1'b0;
            @(posedge clk);
        end
        job_valid <= 1'b1;
        job <= j;
        @(posedge clk);
        while (job_stall)
            @(posedge clk);
        predicted = allocate_room(j);
        pending_grants.push_back(typed ? typed_g : predicted);
    endtask

    task automatic wait_drained();
        job_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only once every grant has come back.
    task automatic set_room_limit(input logic [efra_pkg::CFG_W-1:0] value);
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        room_limit = value;
    endtask

    task automatic report_miss(input string field, input logic [efra_pkg::TIME_W-1:0] want,
                               input logic [efra_pkg::TIME_W-1:0] got);
        mismatches++;
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    endtask

    // Grant side stall: random, or a long hold-off when the stimulus asks for one.
    always @(posedge clk)
    begin
        if (burst_seen != burst_req)
        begin
            burst_seen = burst_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            grant_stall <= 1'b1;
        end
        else
        begin
            grant_stall <= ($urandom_range(99) < grant_stall_pct);
        end
    end

    // Compare each grant transfer with the oldest expectation.
    always @(posedge clk)
    begin
        efra_pkg::grant_t want;
        if (rst_n && grant_valid && !grant_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected grant: room %0d start %0h end %0h", $time,
                         grant.assigned_resource, grant.actual_start, grant.actual_end);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (grant.assigned_resource !== want.assigned_resource)
                    report_miss("assigned_resource",
                                efra_pkg::TIME_W'(want.assigned_resource),
                                efra_pkg::TIME_W'(grant.assigned_resource));
                if (grant.actual_start !== want.actual_start)
                    report_miss("actual_start", want.actual_start, grant.actual_start);
                if (grant.actual_end !== want.actual_end)
                    report_miss("actual_end", want.actual_end, grant.actual_end);
                if (grant.delayed !== want.delayed)
                    report_miss("delayed", efra_pkg::TIME_W'(want.delayed),
                                efra_pkg::TIME_W'(grant.delayed));
                if (grant.most_used_resource !== want.most_used_resource)
                    report_miss("most_used_resource",
                                efra_pkg::TIME_W'(want.most_used_resource),
                                efra_pkg::TIME_W'(grant.most_used_resource));
                if (grant.set_done !== want.set_done)
                    report_miss("set_done", efra_pkg::TIME_W'(want.set_done),
                                efra_pkg::TIME_W'(grant.set_done));
            end
        end
    end

    initial
    begin
        plan_row_t row;
        efra_pkg::job_t j;
        efra_pkg::grant_t unused_g;
        logic [efra_pkg::IN_TIME_W-1:0] job_clock;
        logic [efra_pkg::IN_TIME_W-1:0] span;
        logic [efra_pkg::CFG_W-1:0] phase_cfg [PHASES];

        for (int k = 0; k < efra_pkg::MAX_RESOURCES_DEF; k++)
        begin
            room_busy_until[k] = '0;
            room_use_count[k] = '0;
        end
        top_count = '0;
        top_room = '0;
        room_limit = efra_pkg::CFG_RESET;
        unused_g = '0;
        job_clock = '0;
        phase_cfg = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd4, 5'd2, 5'd9};
        phase_cfg[PHASES-1] = efra_pkg::CFG_W'($urandom_range(1, efra_pkg::MAX_RESOURCES_DEF));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset all rooms are free; full-range times and a zero-length job end the set.
        plan_row(0, 0, 0, 10, 0, 1, 0, 0, 10, 0, 0);
        plan_row(0, 0, 0, 32'hFFFF_FFFF, 0, 1, 1, 0, 48'hFFFF_FFFF, 0, 0);
        plan_row(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, 48'hFFFF_FFFF, 48'hFFFF_FFFF, 0, 0);
        // A count of zero acts as one room; end before start gives a zero-length job.
        plan_row(1, 0, 5, 3, 0, 1, 0, 5, 5, 0, 0);
        plan_row(0, 0, 5, 9, 0);
        plan_row(0, 0, 6, 8, 0, 1, 0, 9, 11, 1, 0);
        plan_row(0, 0, 6, 8, 1);
        // Room 1 leads the use count, then the count shrinks within the set.
        plan_row(1, 2, 0, 1000, 0);
        plan_row(0, 0, 0, 10, 0);
        plan_row(0, 0, 10, 20, 0);
        plan_row(0, 0, 20, 30, 0);
        plan_row(1, 1, 30, 40, 0);
        plan_row(0, 0, 31, 41, 1);
        // Two rooms freeing at the same time: the lower index takes the delayed job.
        plan_row(1, 2, 0, 10, 0);
        plan_row(0, 0, 0, 10, 0);
        plan_row(0, 0, 1, 2, 0);
        plan_row(0, 0, 3, 30, 1);
        // A count above the built maximum acts as the maximum.
        plan_row(1, 31, 0, 32'h8000_0000, 0, 1, 0, 0, 48'h8000_0000, 0, 0);
        plan_row(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 0, 1, 1, 48'h7FFF_FFFF, 48'h7FFF_FFFF, 0, 0);
        plan_row(0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1);
        plan_row(1, 16, 1, 2, 1);

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.wr)
                set_room_limit(row.cfg);
            send_job(row.j, row.typed, row.g);
        end

        // Random phases, each with its own room count and idling pattern.
        for (int p = 0; p < PHASES; p++)
        begin
            set_room_limit(phase_cfg[p]);
            case (p % 4)
                0:
                begin
                    send_gap_pct = 0;
                    grant_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct = 69;
                    grant_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    grant_stall_pct = 69;
                end
                default:
                begin
                    send_gap_pct = 38;
                    grant_stall_pct = 38;
                end
            endcase
            // Hold the grant side off while jobs keep coming, so the block backs up.
            if (p == 2)
                burst_req++;
            for (int n = 0; n < JOBS_PER_PHASE; n++)
            begin
                if (p == 5 && n == JOBS_PER_PHASE / 2)
                    wait_drained();
                if ($urandom_range(9) == 0)
                begin
                    // Noise: unsorted, zero-length, reversed and extreme times.
                    case ($urandom_range(3))
                        0:
                        begin
                            j.start_time = $urandom;
                            j.end_time = $urandom;
                        end
                        1:
                        begin
                            j.start_time = $urandom;
                            j.end_time = j.start_time;
                        end
                        2:
                        begin
                            j.start_time = '1;
                            j.end_time = $urandom;
                        end
                        default:
                        begin
                            j.start_time = $urandom_range(15);
                            j.end_time = '1;
                        end
                    endcase
                end
                else
                begin
                    // Sorted jobs with durations that keep the enabled rooms about busy.
                    if ($urandom_range(29) == 0)
                        job_clock = $urandom_range(1) ? $urandom : 32'hFFFF_FFF0;
                    job_clock = job_clock + $urandom_range(6);
                    span = $urandom_range(1, 6 * active_rooms());
                    j.start_time = job_clock;
                    j.end_time = job_clock + span;
                end
                j.last_job = ($urandom_range(11) == 0);
                send_job(j, 1'b0, unused_g);
            end
        end

        // Let every grant come back, then watch for stray ones.
        send_gap_pct = 0;
        grant_stall_pct = 0;
        wait_drained();
        repeat (2 * (efra_pkg::MAX_RESOURCES_DEF + 3)) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: earliest_free_room_allocator_unit.f
src/efra_pkg.sv
src/earliest_free_room_allocator_unit.sv
test/tb.sv
